[rtl/lss_pkg.sv]
`default_nettype none

package lss_pkg;

  // Fixed widths of the command and result fields.
  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int FIELD_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF        = 64;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

endpackage

`default_nettype wire

[rtl/searchable_lifo_stack.sv]
`default_nettype none
// Push and any command that fails at once answer in the cycle after acceptance with busy
// kept low, so they can follow every cycle; pop and read stay busy through the memory
// read and the fetch state. Find walks down from the top until a key matches or the
// bottom is passed; delete answers once its record is read, then stays busy while the
// records above move down, all through the single read port; the receiver cannot stall.
// Reset is synchronous: it empties the stack and idles the control; memory is not cleared.

module searchable_lifo_stack
  import lss_pkg::*;
#(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [CMD_W-1:0]    in_command,
  input  wire  [POS_W-1:0]    in_position,
  input  wire  [FIELD_W-1:0]  in_key,
  input  wire  [FIELD_W-1:0]  in_payload,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [FIELD_W-1:0]  out_key_out,
  output logic [FIELD_W-1:0]  out_payload_out,
  output logic [POS_W-1:0]    out_position_out,
  output logic [COUNT_W-1:0]  out_count
);

  // Address width of the record memory, width of the record count (which must hold DEPTH
  // itself), the width of one stored record, and a common width for position compares.
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int RW   = KEY_BITS + PAYLOAD_BITS;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Records are stored with the key in the upper bits and the payload in the lower bits.
  // The bottom record sits at address 0 and the top record at address count - 1.
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FETCH    = 5'b00010,
    ST_SCAN     = 5'b00100,
    ST_DEL_HEAD = 5'b01000,
    ST_SHIFT    = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [KEY_BITS-1:0]     key_q_r, key_q_nxt;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [KEY_BITS-1:0]     out_key_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic                    emit;
  status_t                 emit_status;
  logic [KEY_BITS-1:0]     emit_key;
  logic [PAYLOAD_BITS-1:0] emit_pay;
  logic [POS_W-1:0]        emit_pos;

  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  logic [RW-1:0]           ram_wr_data;
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [RW-1:0]           ram_rd_data;

  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    full;
  logic                    empty;
  logic                    pos_ok;
  logic [AW-1:0]           top_addr;
  logic [AW-1:0]           pos_addr;

  assign rd_key = ram_rd_data[RW-1 -: KEY_BITS];
  assign rd_pay = ram_rd_data[PAYLOAD_BITS-1:0];

  assign full   = (fill_r == CW'(DEPTH));
  assign empty  = (fill_r == '0);
  // A position is valid only when it lies below the current record count.
  assign pos_ok = (CMPW'(in_position) < CMPW'(fill_r));
  // Positions count down from the top, so the address is count - 1 - position.
  assign top_addr = AW'(fill_r - CW'(1));
  assign pos_addr = AW'(fill_r - CW'(1) - CW'(in_position));

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    addr_nxt    = addr_r;
    key_q_nxt   = key_q_r;
    emit        = 1'b0;
    emit_status = STATUS_MISS;
    emit_key    = '0;
    emit_pay    = '0;
    emit_pos    = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = addr_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_r;
    ram_wr_data = ram_rd_data;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(in_command))
            CMD_PUSH: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STATUS_FULL;
              end else begin
                // The new record goes straight into the first free entry.
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(fill_r);
                ram_wr_data = {in_key[KEY_BITS-1:0], in_payload[PAYLOAD_BITS-1:0]};
                fill_nxt    = fill_r + CW'(1);
                emit_status = STATUS_OK;
              end
            end
            CMD_POP: begin
              if (empty) begin
                emit = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = top_addr;
                fill_nxt    = fill_r - CW'(1);
                state_nxt   = ST_FETCH;
              end
            end
            CMD_READ: begin
              if (pos_ok) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos_addr;
                state_nxt   = ST_FETCH;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_FIND: begin
              key_q_nxt = in_key[KEY_BITS-1:0];
              if (empty) begin
                emit = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = top_addr;
                addr_nxt    = top_addr;
                state_nxt   = ST_SCAN;
              end
            end
            CMD_DELETE: begin
              if (pos_ok) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos_addr;
                addr_nxt    = pos_addr;
                fill_nxt    = fill_r - CW'(1);
                state_nxt   = ST_DEL_HEAD;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        emit        = 1'b1;
        emit_status = STATUS_OK;
        emit_key    = rd_key;
        emit_pay    = rd_pay;
        state_nxt   = ST_IDLE;
      end

      ST_SCAN: begin
        // The read data belongs to addr_r; the next entry down is read while this one
        // is compared, so the walk covers one record per cycle.
        if (rd_key == key_q_r) begin
          emit        = 1'b1;
          emit_status = STATUS_OK;
          emit_key    = rd_key;
          emit_pay    = rd_pay;
          emit_pos    = POS_W'(fill_r - CW'(addr_r) - CW'(1));
          state_nxt   = ST_IDLE;
        end else if (addr_r == '0) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = addr_r - AW'(1);
          addr_nxt    = addr_r - AW'(1);
        end
      end

      ST_DEL_HEAD: begin
        // The count is already reduced here, so records above the deleted one exist
        // exactly when its address is below the new count.
        emit        = 1'b1;
        emit_status = STATUS_OK;
        emit_key    = rd_key;
        emit_pay    = rd_pay;
        if (CW'(addr_r) < fill_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = addr_r + AW'(1);
          state_nxt   = ST_SHIFT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SHIFT: begin
        // Each record above the gap moves down one entry. The read always runs one entry
        // ahead of the write, so no entry is read after it has been overwritten.
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r;
        ram_wr_data = ram_rd_data;
        if ((CW'(addr_r) + CW'(1)) < fill_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = addr_r + AW'(2);
          addr_nxt    = addr_r + AW'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= emit;
    end
  end

  // Working and result data need no reset; out_valid qualifies the result.
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    key_q_r <= key_q_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_key_r    <= emit_key;
      out_pay_r    <= emit_pay;
      out_pos_r    <= emit_pos;
      out_count_r  <= COUNT_W'(fill_nxt);
    end
  end

  lss_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_key_out      = FIELD_W'(out_key_r);
  assign out_payload_out  = FIELD_W'(out_pay_r);
  assign out_position_out = out_pos_r;
  assign out_count        = out_count_r;

endmodule

`default_nettype wire

[rtl/lss_ram.sv]
`default_nettype none

module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              wr_en,
  input  wire  [AW-1:0]    wr_addr,
  input  wire  [WIDTH-1:0] wr_data,
  input  wire              rd_en,
  input  wire  [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/lss_chk.sv]
`default_nettype none

module lss_chk
  import lss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input wire                out_valid,
  input wire [STATUS_W-1:0] out_status,
  input wire [FIELD_W-1:0]  out_key_out,
  input wire [FIELD_W-1:0]  out_payload_out,
  input wire [POS_W-1:0]    out_position_out,
  input wire [COUNT_W-1:0]  out_count
);

  // An accepted command either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted command neither answered nor started work");

  // While idle with nothing accepted, no result may appear.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !out_valid)
    else $error("result without an accepted command");

  // A failed command carries no record and no position.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
      (out_key_out == '0) && (out_payload_out == '0) && (out_position_out == '0))
    else $error("failed command returned record data");

  // A full stack reports the capacity as its count.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> out_count == COUNT_W'(DEPTH))
    else $error("full status with a count other than the depth");

endmodule

bind searchable_lifo_stack lss_chk #(
  .DEPTH (DEPTH)
) u_lss_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_key_out      (out_key_out),
  .out_payload_out  (out_payload_out),
  .out_position_out (out_position_out),
  .out_count        (out_count)
);

`default_nettype wire

[sim/stack_result_checker.sv]
`timescale 1ns / 100ps

module stack_result_checker
  import lss_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 busy,
  input  wire  [CMD_W-1:0]    in_command,
  input  wire  [POS_W-1:0]    in_position,
  input  wire  [FIELD_W-1:0]  in_key,
  input  wire  [FIELD_W-1:0]  in_payload,
  input  wire                 out_valid,
  input  wire  [STATUS_W-1:0] out_status,
  input  wire  [FIELD_W-1:0]  out_key_out,
  input  wire  [FIELD_W-1:0]  out_payload_out,
  input  wire  [POS_W-1:0]    out_position_out,
  input  wire  [COUNT_W-1:0]  out_count,
  output int unsigned         mismatch_total,
  output int unsigned         awaited_count
);

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam logic [FIELD_W-1:0] KEY_MASK = {FIELD_W{1'b1}} >> (FIELD_W - KEY_BITS_DEF);
  localparam logic [FIELD_W-1:0] PAY_MASK = {FIELD_W{1'b1}} >> (FIELD_W - PAYLOAD_BITS_DEF);

  typedef struct {
    status_t              status;
    logic [FIELD_W-1:0]   key;
    logic [FIELD_W-1:0]   payload;
    logic [POS_W-1:0]     position;
    logic [COUNT_W-1:0]   count;
  } stack_result_t;

  // Shadow copy of the stack: index 0 is the bottom record.
  logic [FIELD_W-1:0] shadow_keys     [STACK_DEPTH];
  logic [FIELD_W-1:0] shadow_payloads [STACK_DEPTH];
  int unsigned        shadow_fill;

  stack_result_t awaited_results[$];
  int unsigned   results_seen;

  task automatic tally_mismatch(input string field, input logic [FIELD_W-1:0] got,
                                input logic [FIELD_W-1:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, field, got,
             want);
    mismatch_total++;
  endtask

  // Works out the one result that a command causes and updates the shadow stack.
  task automatic predict_stack_result(input logic [CMD_W-1:0] cmd,
                                      input logic [POS_W-1:0] pos,
                                      input logic [FIELD_W-1:0] key,
                                      input logic [FIELD_W-1:0] pay);
    stack_result_t r;
    int            i;
    int            idx;
    logic [FIELD_W-1:0] sought;
    r.status   = STATUS_MISS;
    r.key      = '0;
    r.payload  = '0;
    r.position = '0;
    sought     = key & KEY_MASK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_keys[shadow_fill]     = sought;
          shadow_payloads[shadow_fill] = pay & PAY_MASK;
          shadow_fill++;
          r.status = STATUS_OK;
        end
      end
      CMD_POP: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          r.key     = shadow_keys[shadow_fill];
          r.payload = shadow_payloads[shadow_fill];
          r.status  = STATUS_OK;
        end
      end
      CMD_READ: begin
        if (pos < shadow_fill) begin
          idx       = shadow_fill - 1 - pos;
          r.key     = shadow_keys[idx];
          r.payload = shadow_payloads[idx];
          r.status  = STATUS_OK;
        end
      end
      CMD_FIND: begin
        // The walk starts at the top, so the topmost duplicate wins.
        for (i = shadow_fill; i > 0; i--) begin
          if (shadow_keys[i-1] == sought) begin
            r.key      = shadow_keys[i-1];
            r.payload  = shadow_payloads[i-1];
            r.position = POS_W'(shadow_fill - i);
            r.status   = STATUS_OK;
            break;
          end
        end
      end
      CMD_DELETE: begin
        if (pos < shadow_fill) begin
          idx       = shadow_fill - 1 - pos;
          r.key     = shadow_keys[idx];
          r.payload = shadow_payloads[idx];
          for (i = idx; i + 1 < shadow_fill; i++) begin
            shadow_keys[i]     = shadow_keys[i+1];
            shadow_payloads[i] = shadow_payloads[i+1];
          end
          shadow_fill--;
          r.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(shadow_fill);
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      shadow_fill    = 0;
      results_seen   = 0;
      mismatch_total = 0;
      awaited_results.delete();
    end else begin
      // A result at this edge always belongs to an item accepted earlier.
      if ($isunknown(out_valid)) begin
        tally_mismatch("out_valid unknown", FIELD_W'(out_valid), '0);
      end else if (out_valid) begin
        if (awaited_results.size() == 0) begin
          tally_mismatch("unexpected result", FIELD_W'(out_status), '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            tally_mismatch("status", FIELD_W'(out_status), FIELD_W'(want.status));
          if (out_key_out !== want.key)
            tally_mismatch("key", out_key_out, want.key);
          if (out_payload_out !== want.payload)
            tally_mismatch("payload", out_payload_out, want.payload);
          if (out_position_out !== want.position)
            tally_mismatch("position", FIELD_W'(out_position_out), FIELD_W'(want.position));
          if (out_count !== want.count)
            tally_mismatch("count", FIELD_W'(out_count), FIELD_W'(want.count));
        end
        results_seen++;
      end
      if (start === 1'b1 && busy === 1'b0)
        predict_stack_result(in_command, in_position, in_key, in_payload);
    end
    awaited_count = awaited_results.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lss_pkg::*;

  // Command codes 5 to 7 are not defined; the block must answer them with a miss.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // No correct run goes this many cycles without an item or a result moving.
  // The slowest item is a find or a delete that walks all 64 records.
  localparam int STALL_LIMIT = 2000;

  // Cycles allowed after the last result, enough for a delete to finish its shift.
  localparam int DRAIN_CYCLES = 80;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic [CMD_W-1:0]   in_command;
  logic [POS_W-1:0]   in_position;
  logic [FIELD_W-1:0] in_key;
  logic [FIELD_W-1:0] in_payload;

  wire                busy;
  wire                out_valid;
  wire [STATUS_W-1:0] out_status;
  wire [FIELD_W-1:0]  out_key_out;
  wire [FIELD_W-1:0]  out_payload_out;
  wire [POS_W-1:0]    out_position_out;
  wire [COUNT_W-1:0]  out_count;

  int unsigned mismatch_total;
  int unsigned results_outstanding;
  int unsigned quiet_cycles;

  // Chance, in percent, that the sender idles in any one cycle between items.
  int unsigned idle_pct;

  // A small set of keys that most items reuse, so that find hits and duplicates occur.
  logic [FIELD_W-1:0] key_pool [8];

  searchable_lifo_stack u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_key_out      (out_key_out),
    .out_payload_out  (out_payload_out),
    .out_position_out (out_position_out),
    .out_count        (out_count)
  );

  stack_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_key_out      (out_key_out),
    .out_payload_out  (out_payload_out),
    .out_position_out (out_position_out),
    .out_count        (out_count),
    .mismatch_total   (mismatch_total),
    .awaited_count    (results_outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The watchdog restarts whenever an item is accepted or a result comes out.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly keys from the pool, so that searches find something; the rest are fresh.
  function automatic logic [FIELD_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 60)
      return key_pool[$urandom_range(0, 7)];
    return rand_word();
  endfunction

  // Mostly positions near the top, where they tend to be in range; the rest anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 75)
      return POS_W'($urandom_range(0, 7));
    return POS_W'($urandom_range(0, 63));
  endfunction

  // Presents one item from a falling edge, holds it until the block takes it, then
  // idles cycle by cycle at random. The start line is only lowered when the sender
  // idles, so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [FIELD_W-1:0] key, input logic [FIELD_W-1:0] pay);
    in_command  <= cmd;
    in_position <= pos;
    in_key      <= key;
    in_payload  <= pay;
    start       <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Lowers start and holds off until the block is idle and every result is in.
  // The loop waits before it checks, so start is never lowered and raised in one step.
  task automatic wait_until_settled();
    start <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0 || busy);
  endtask

  // A run of random commands, with pushes taking the given share.
  task automatic run_mix(input int n, input int push_pct);
    int               k;
    int               r;
    logic [CMD_W-1:0] cmd;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        cmd = CMD_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20)      cmd = CMD_POP;
        else if (r < 45) cmd = CMD_READ;
        else if (r < 75) cmd = CMD_FIND;
        else if (r < 95) cmd = CMD_DELETE;
        else             cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      send_item(cmd, pick_position(), pick_key(), rand_word());
    end
  endtask

  // The same command many times over: enough pushes fill the stack from any state
  // and then hit the full case, and enough pops empty it and then underflow.
  task automatic run_burst(input int n, input logic [CMD_W-1:0] cmd);
    int k;
    for (k = 0; k < n; k++)
      send_item(cmd, pick_position(), pick_key(), rand_word());
  endtask

  initial begin
    int phase;
    int c;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_PUSH;
    in_position = '0;
    in_key      = '0;
    in_payload  = '0;
    idle_pct    = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (c = 2; c < 8; c++)
      key_pool[c] = rand_word();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Every command on an empty stack should miss.
    send_item(CMD_POP,    '0, '0, '0);
    send_item(CMD_READ,   '0, '0, '0);
    send_item(CMD_DELETE, '0, '0, '0);
    send_item(CMD_FIND,   '0, '0, '0);

    // Pushes with extreme and alternating bit patterns, the all-ones key twice.
    send_item(CMD_PUSH, '0, '1, '0);
    send_item(CMD_PUSH, '0, '0, '1);
    send_item(CMD_PUSH, '0, {32{2'b10}}, {32{2'b01}});
    send_item(CMD_PUSH, '0, {32{2'b01}}, {32{2'b10}});
    send_item(CMD_PUSH, '0, '1, 64'h0123_4567_89ab_cdef);

    // Find returns the topmost duplicate; the zero key sits three below the top.
    send_item(CMD_FIND, '0, '1, '0);
    send_item(CMD_FIND, '0, '0, '0);
    send_item(CMD_FIND, '0, 64'h1234, '0);

    // Reads at the top, at the bottom, just past the bottom and at the last position.
    send_item(CMD_READ, 6'd0,  '0, '0);
    send_item(CMD_READ, 6'd4,  '0, '0);
    send_item(CMD_READ, 6'd5,  '0, '0);
    send_item(CMD_READ, '1,    '0, '0);

    // Deletes in the middle, at the bottom, at the top and out of range.
    send_item(CMD_DELETE, 6'd2, '0, '0);
    send_item(CMD_DELETE, 6'd3, '0, '0);
    send_item(CMD_DELETE, 6'd0, '0, '0);
    send_item(CMD_DELETE, '1,   '0, '0);

    // The undefined command codes, with all fields at random.
    for (c = int'(CMD_SPARE_LO); c <= int'(CMD_SPARE_HI); c++)
      send_item(CMD_W'(c), POS_W'($urandom), rand_word(), rand_word());

    send_item(CMD_POP, '0, '0, '0);
    send_item(CMD_POP, '0, '0, '0);

    // Random part, in phases of different sender idling. Each phase begins after
    // the block has gone quiet, then mixes commands, fills the stack past full,
    // works on a full stack where the walks are longest, and drains it past empty.
    for (phase = 0; phase < 4; phase++) begin
      wait_until_settled();
      case (phase)
        1:       idle_pct = 52;
        3:       idle_pct = 11;
        default: idle_pct = 0;
      endcase
      run_mix(20, 50);
      run_burst(70, CMD_PUSH);
      run_mix(30, 10);
      run_burst(66, CMD_POP);
    end

    // Wait for every result, then long enough for a trailing shift to finish.
    wait_until_settled();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
